// ----- hw/rtl/dpr_pkg.sv -----
package dpr_pkg;

	localparam int unsigned RAW_W   = 33;
	localparam int unsigned GAIN_W  = 48;
	localparam int unsigned SAT_W   = 32;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned ROW_W   = 16;
	localparam int unsigned MROW_W  = 10;
	localparam int unsigned MCOL_W  = 11;
	localparam int unsigned PROD_W  = 80;

	typedef struct packed {
		logic signed [RAW_W-1:0] raw_value;
		logic                    frame_start;
	} dpr_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] pixel_class;
	} dpr_out_t;

	typedef struct packed {
		logic [KIND_W-1:0] detector_kind;
		logic [ROW_W-1:0]  row_width;
	} dpr_geom_t;

	localparam logic [1:0] REG_GAIN  = 2'd0;
	localparam logic [1:0] REG_SAT   = 2'd1;
	localparam logic [1:0] REG_KIND  = 2'd2;
	localparam logic [1:0] REG_WIDTH = 2'd3;

	localparam logic [KIND_W-1:0] KIND_GENERIC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NARROW  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WIDE    = 2'd2;

	localparam logic [1:0] CLS_GRAY     = 2'd0;
	localparam logic [1:0] CLS_GAP      = 2'd1;
	localparam logic [1:0] CLS_INACTIVE = 2'd2;
	localparam logic [1:0] CLS_SAT      = 2'd3;

	localparam logic [GAIN_W-1:0] GAIN_RESET  = 48'h0001_0000_0000;
	localparam logic [SAT_W-1:0]  SAT_RESET   = 32'd65535;
	localparam logic [ROW_W-1:0]  WIDTH_RESET = 16'd2463;

	localparam logic [RAW_W-1:0] RAW_INACTIVE = 33'h1_FFFF_FFFE;

	localparam logic [MROW_W-1:0] NARROW_ROW_MOD = 10'd212;
	localparam logic [MCOL_W-1:0] NARROW_COL_MOD = 11'd494;
	localparam logic [MROW_W-1:0] NARROW_ROW_ACT = 10'd195;
	localparam logic [MCOL_W-1:0] NARROW_COL_ACT = 11'd487;
	localparam logic [MROW_W-1:0] WIDE_ROW_MOD   = 10'd551;
	localparam logic [MCOL_W-1:0] WIDE_COL_MOD   = 11'd1040;
	localparam logic [MROW_W-1:0] WIDE_ROW_ACT   = 10'd514;
	localparam logic [MCOL_W-1:0] WIDE_COL_ACT   = 11'd1030;

	localparam logic [7:0] GAP_R      = 8'd255;
	localparam logic [7:0] GAP_GB     = 8'd228;
	localparam logic [7:0] INACT_R    = 8'd245;
	localparam logic [7:0] INACT_GB   = 8'd1;
	localparam logic [7:0] SAT_RG     = 8'd254;
	localparam logic [7:0] SAT_B      = 8'd1;
	localparam logic [7:0] GRAY_WHITE = 8'd255;
	localparam logic [7:0] GRAY_BLACK = 8'd0;
	localparam logic [8:0] GRAY_SPAN  = 9'd256;

endpackage

// ----- hw/rtl/dpr_pos.sv -----
module dpr_pos
	import dpr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  logic      frame_start,
	input  dpr_geom_t geom,
	output logic      gap
);

	logic [ROW_W-1:0]  column_count_q;
	logic [MROW_W-1:0] module_row_count_q;
	logic [MCOL_W-1:0] module_column_count_q;

	logic [ROW_W-1:0]  col_cur;
	logic [MROW_W-1:0] mrow_cur;
	logic [MCOL_W-1:0] mcol_cur;
	logic [MROW_W-1:0] row_mod;
	logic [MROW_W-1:0] row_act;
	logic [MCOL_W-1:0] col_mod;
	logic [MCOL_W-1:0] col_act;
	logic [ROW_W:0]    width_eff;
	logic [ROW_W:0]    col_inc;
	logic [MROW_W:0]   mrow_inc;
	logic [MCOL_W:0]   mcol_inc;
	logic              row_end;
	logic              gapped;

	assign col_cur  = frame_start ? '0 : column_count_q;
	assign mrow_cur = frame_start ? '0 : module_row_count_q;
	assign mcol_cur = frame_start ? '0 : module_column_count_q;

	always_comb begin
		if (geom.detector_kind == KIND_WIDE) begin
			row_mod = WIDE_ROW_MOD;
			col_mod = WIDE_COL_MOD;
			row_act = WIDE_ROW_ACT;
			col_act = WIDE_COL_ACT;
		end else begin
			row_mod = NARROW_ROW_MOD;
			col_mod = NARROW_COL_MOD;
			row_act = NARROW_ROW_ACT;
			col_act = NARROW_COL_ACT;
		end
	end

	assign gapped = (geom.detector_kind == KIND_NARROW) || (geom.detector_kind == KIND_WIDE);
	assign gap    = gapped && !((mrow_cur < row_act) && (mcol_cur < col_act));

	assign width_eff = (geom.row_width == '0) ? (ROW_W+1)'(1) : {1'b0, geom.row_width};
	assign col_inc   = {1'b0, col_cur} + (ROW_W+1)'(1);
	assign mrow_inc  = {1'b0, mrow_cur} + (MROW_W+1)'(1);
	assign mcol_inc  = {1'b0, mcol_cur} + (MCOL_W+1)'(1);
	assign row_end   = col_inc >= width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q        <= '0;
			module_row_count_q    <= '0;
			module_column_count_q <= '0;
		end else if (advance) begin
			if (row_end) begin
				column_count_q        <= '0;
				module_column_count_q <= '0;
				module_row_count_q    <= (mrow_inc >= {1'b0, row_mod}) ? '0 : mrow_inc[MROW_W-1:0];
			end else begin
				column_count_q        <= col_inc[ROW_W-1:0];
				module_column_count_q <= (mcol_inc >= {1'b0, col_mod}) ? '0 : mcol_inc[MCOL_W-1:0];
			end
		end
	end

endmodule

// ----- hw/rtl/detector_pixel_to_rgb.sv -----
// Channel   Handshake                 Payload
// in        in_valid / in_ready       in_data  (dpr_in_t)
// out       out_valid / out_ready     out_data (dpr_out_t)
// cfg       cfg_wr_en                 cfg_index, cfg_data
//
// Stages, one pixel per cycle while out_ready holds: input register, gain multiplier
// stage (two partial products), then product sum and colour into the output register.
// Reset clears the valid flags and position counters and loads register defaults.
// A stall at the output holds each stage that is full; an empty stage still fills,
// so in_ready stays high while any bubble remains in the pipe.
module detector_pixel_to_rgb
	import dpr_pkg::*;
#(
	parameter int unsigned GAIN_FRACTION_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dpr_in_t           in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output dpr_out_t          out_data,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [GAIN_W-1:0] cfg_data
);

	localparam int unsigned SHIFT = GAIN_FRACTION_BITS - 8;

	logic [GAIN_W-1:0] correction_gain_q;
	logic [SAT_W-1:0]  saturation_level_q;
	logic [KIND_W-1:0] detector_kind_q;
	logic [ROW_W-1:0]  row_width_q;

	logic              adv1, adv2, adv3, accept;
	logic              gap;
	dpr_geom_t         geom;

	logic              v_s1;
	logic [RAW_W-1:0]  raw_s1;
	logic              gap_s1;

	logic              v_s2;
	logic [1:0]        cls_s2;
	logic              neg_s2;
	logic [47:0]       hi_s2;
	logic [63:0]       lo_s2;

	logic [1:0]        cls_next;
	logic [47:0]       prod_hi;
	logic [63:0]       prod_lo;
	logic [PROD_W-1:0] prod;
	logic [7:0]        gray;
	logic [8:0]        gray_sub;
	dpr_out_t          out_next;
	dpr_out_t          out_q;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			correction_gain_q  <= GAIN_RESET;
			saturation_level_q <= SAT_RESET;
			detector_kind_q    <= KIND_GENERIC;
			row_width_q        <= WIDTH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GAIN:  correction_gain_q  <= cfg_data;
				REG_SAT:   saturation_level_q <= cfg_data[SAT_W-1:0];
				REG_KIND:  detector_kind_q    <= cfg_data[KIND_W-1:0];
				REG_WIDTH: row_width_q        <= cfg_data[ROW_W-1:0];
				default:   ;
			endcase
		end
	end

	assign adv3     = !out_valid_q || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign accept   = in_valid && in_ready;

	assign geom.detector_kind = detector_kind_q;
	assign geom.row_width     = row_width_q;

	dpr_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.frame_start (in_data.frame_start),
		.geom        (geom),
		.gap         (gap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= in_data.raw_value;
			gap_s1 <= gap;
		end
	end

	always_comb begin
		if (gap_s1) begin
			cls_next = CLS_GAP;
		end else if (raw_s1 == RAW_INACTIVE) begin
			cls_next = CLS_INACTIVE;
		end else if (!raw_s1[RAW_W-1] && (raw_s1[SAT_W-1:0] >= saturation_level_q)) begin
			cls_next = CLS_SAT;
		end else begin
			cls_next = CLS_GRAY;
		end
	end

	assign prod_hi = raw_s1[31:0] * correction_gain_q[47:32];
	assign prod_lo = raw_s1[31:0] * correction_gain_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			cls_s2 <= cls_next;
			neg_s2 <= raw_s1[RAW_W-1];
			hi_s2  <= prod_hi;
			lo_s2  <= prod_lo;
		end
	end

	assign prod     = {hi_s2, 32'd0} + {16'd0, lo_s2};
	assign gray_sub = GRAY_SPAN - {1'b0, prod[GAIN_FRACTION_BITS-1:SHIFT]}
	                - {8'd0, |prod[SHIFT-1:0]};

	always_comb begin
		if (neg_s2 || (prod == '0)) begin
			gray = GRAY_WHITE;
		end else if (|prod[PROD_W-1:GAIN_FRACTION_BITS]) begin
			gray = GRAY_BLACK;
		end else begin
			gray = gray_sub[7:0];
		end
	end

	always_comb begin
		out_next.pixel_class = cls_s2;
		case (cls_s2)
			CLS_GAP: begin
				out_next.red   = GAP_R;
				out_next.green = GAP_GB;
				out_next.blue  = GAP_GB;
			end
			CLS_INACTIVE: begin
				out_next.red   = INACT_R;
				out_next.green = INACT_GB;
				out_next.blue  = INACT_GB;
			end
			CLS_SAT: begin
				out_next.red   = SAT_RG;
				out_next.green = SAT_RG;
				out_next.blue  = SAT_B;
			end
			default: begin
				out_next.red   = gray;
				out_next.green = gray;
				out_next.blue  = gray;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv3) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			out_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv3 |=> v_s2 && $stable(lo_s2) && $stable(hi_s2) && $stable(cls_s2))
		else $error("multiplier stage changed while stalled");

	a_frame_start_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.frame_start |=> v_s1 && !gap_s1)
		else $error("first pixel of a frame flagged as gap");

	a_gray_is_gray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pixel_class == CLS_GRAY
		|-> out_data.red == out_data.green && out_data.green == out_data.blue)
		else $error("gray pixel with unequal channels");
`endif

endmodule
